>>> design/blpg_pkg.sv
package blpg_pkg;

    localparam int CFG_W      = 13;
    localparam int COORD_W    = 14;
    localparam int DIM_W      = 14;
    localparam int COL_IN_W   = 16;
    localparam int COL_W      = 8;
    localparam int ADDR_W     = 24;
    localparam int DELTA_W    = 15;
    localparam int ERR_W      = 17;
    localparam int REG_IDX_W  = 1;
    localparam int NUM_CHAN   = 4;

    localparam int MAX_DIM_DEFAULT = 4096;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef logic [COL_W-1:0] colour_t [NUM_CHAN];

    // saturate a signed channel into 0..255
    function automatic logic [COL_W-1:0] clamp_colour(input logic signed [COL_IN_W-1:0] c);
        logic [COL_W-1:0] r;
        if (c < 0)
            r = '0;
        else if (c > 16'sd255)
            r = '1;
        else
            r = c[COL_W-1:0];
        return r;
    endfunction

endpackage

>>> design/bresenham_line_pixel_generator.sv
// a tick passes the state/clip stage, then the address multiply stage, before its pixel is presented
// throughput: one word per cycle on both channels, loads and ticks alike, while px_ready does not hold the pipeline
// a load word produces no pixel; a tick produces exactly one pixel word
// the address multiplier (row times width) sets the second stage
// reset (rst_n low, asynchronous): no line active, screen 640x480, pipeline empty
module bresenham_line_pixel_generator
    import blpg_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [REG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    // command channel
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  logic                        kind,
    input  logic signed [COORD_W-1:0]   start_x,
    input  logic signed [COORD_W-1:0]   start_y,
    input  logic signed [COORD_W-1:0]   end_x,
    input  logic signed [COORD_W-1:0]   end_y,
    input  logic signed [COL_IN_W-1:0]  red_in,
    input  logic signed [COL_IN_W-1:0]  green_in,
    input  logic signed [COL_IN_W-1:0]  blue_in,
    input  logic signed [COL_IN_W-1:0]  alpha_in,
    // pixel channel
    output logic                        px_valid,
    input  logic                        px_ready,
    output logic signed [COORD_W-1:0]   pixel_x,
    output logic signed [COORD_W-1:0]   pixel_y,
    output logic [ADDR_W-1:0]           pixel_address,
    output logic [COL_W-1:0]            red_out,
    output logic [COL_W-1:0]            green_out,
    output logic [COL_W-1:0]            blue_out,
    output logic [COL_W-1:0]            alpha_out,
    output logic                        on_screen,
    output logic                        last_pixel,
    output logic                        idle
);

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);
    localparam int PROD_W = (COORD_W - 1) + DIM_W;

    // screen size registers
    logic [CFG_W-1:0] width_reg, height_reg;

    // line state
    logic                       active_reg;
    logic                       is_steep_reg;
    logic signed [COORD_W-1:0]  major_pos_reg, major_end_reg, minor_pos_reg;
    logic                       minor_dir_reg;
    logic [DELTA_W-1:0]         delta_major_reg, delta_minor_reg;
    logic signed [ERR_W-1:0]    error_acc_reg;
    colour_t                    colour_reg;

    // stage 1: clipped pixel
    logic                       s1_valid_reg;
    logic signed [COORD_W-1:0]  s1_x_reg, s1_y_reg;
    logic [DIM_W-1:0]           s1_w_reg;
    logic                       s1_on_reg, s1_last_reg, s1_idle_reg;
    colour_t                    s1_colour_reg;

    // stage 2: result register
    logic                       out_valid_reg;
    logic signed [COORD_W-1:0]  out_x_reg, out_y_reg;
    logic [ADDR_W-1:0]          out_addr_reg;
    colour_t                    out_colour_reg;
    logic                       out_on_reg, out_last_reg, out_idle_reg;

    // handshake: each stage moves when the one after it has room
    logic s2_en, s1_adv, accept, tick_acc, load_acc;

    assign s2_en     = !out_valid_reg || px_ready;
    assign s1_adv    = s1_valid_reg && s2_en;
    assign cmd_ready = !s1_valid_reg || s2_en;
    assign accept    = cmd_valid && cmd_ready;
    assign tick_acc  = accept && (kind == KIND_TICK);
    assign load_acc  = accept && (kind == KIND_LOAD);

    // load setup: steep test, axis swap, endpoint ordering
    logic signed [DELTA_W-1:0]  ddx, ddy, adx, ady, ld_dy;
    logic                       ld_steep;
    logic signed [COORD_W-1:0]  sx0, sy0, sx1, sy1;
    logic signed [COORD_W-1:0]  ox0, oy0, ox1, oy1;
    logic signed [DELTA_W-1:0]  ld_dmaj;

    always_comb
    begin
        ddx = DELTA_W'(start_x) - DELTA_W'(end_x);
        ddy = DELTA_W'(start_y) - DELTA_W'(end_y);
        adx = ddx[DELTA_W-1] ? -ddx : ddx;
        ady = ddy[DELTA_W-1] ? -ddy : ddy;
        ld_steep = $unsigned(adx) < $unsigned(ady);
        sx0 = ld_steep ? start_y : start_x;
        sy0 = ld_steep ? start_x : start_y;
        sx1 = ld_steep ? end_y   : end_x;
        sy1 = ld_steep ? end_x   : end_y;
        if (sx0 > sx1)
        begin
            ox0 = sx1;
            oy0 = sy1;
            ox1 = sx0;
            oy1 = sy0;
        end
        else
        begin
            ox0 = sx0;
            oy0 = sy0;
            ox1 = sx1;
            oy1 = sy1;
        end
        ld_dy   = DELTA_W'(oy1) - DELTA_W'(oy0);
        ld_dmaj = DELTA_W'(ox1) - DELTA_W'(ox0);
    end

    // tick: clip current pixel and advance the error term
    logic [DIM_W-1:0]           w_eff, h_eff;
    logic signed [COORD_W:0]    x_ext, y_ext, w_s, h_s, x_pb, y_pb;
    logic                       pix_on, pix_last, minor_step;
    logic signed [ERR_W-1:0]    err_add;
    logic signed [ERR_W:0]      err_twice;

    always_comb
    begin
        w_eff = ({1'b0, width_reg}  > MAX_DIM_V) ? MAX_DIM_V : {1'b0, width_reg};
        h_eff = ({1'b0, height_reg} > MAX_DIM_V) ? MAX_DIM_V : {1'b0, height_reg};
        w_s   = signed'({1'b0, w_eff});
        h_s   = signed'({1'b0, h_eff});
        x_ext = (COORD_W+1)'(is_steep_reg ? minor_pos_reg : major_pos_reg);
        y_ext = (COORD_W+1)'(is_steep_reg ? major_pos_reg : minor_pos_reg);
        // a coordinate sitting exactly on the far edge is pulled back inside
        x_pb  = (x_ext == w_s) ? x_ext - (COORD_W+1)'(1) : x_ext;
        y_pb  = (y_ext == h_s) ? y_ext - (COORD_W+1)'(1) : y_ext;
        pix_on = !x_pb[COORD_W] && (x_pb < w_s) && !y_pb[COORD_W] && (y_pb < h_s);
        pix_last = major_pos_reg >= major_end_reg;
        err_add = error_acc_reg + signed'(ERR_W'(delta_minor_reg));
        err_twice = {err_add, 1'b0};
        minor_step = err_twice > signed'((ERR_W+1)'(delta_major_reg));
    end

    // address stage: row times width plus column
    logic [PROD_W-1:0] addr_full;

    assign addr_full = PROD_W'(s1_y_reg[COORD_W-2:0]) * PROD_W'(s1_w_reg)
                     + PROD_W'(s1_x_reg[COORD_W-2:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= WIDTH_RESET;
            height_reg      <= HEIGHT_RESET;
            active_reg      <= 1'b0;
            is_steep_reg    <= 1'b0;
            major_pos_reg   <= '0;
            major_end_reg   <= '0;
            minor_pos_reg   <= '0;
            minor_dir_reg   <= 1'b0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            error_acc_reg   <= '0;
            colour_reg      <= '{default: '0};
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_SCREEN_WIDTH)
                width_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_SCREEN_HEIGHT)
                height_reg <= cfg_data;

            if (load_acc)
            begin
                // a new line replaces whatever was in flight
                active_reg      <= 1'b1;
                is_steep_reg    <= ld_steep;
                major_pos_reg   <= ox0;
                major_end_reg   <= ox1;
                minor_pos_reg   <= oy0;
                minor_dir_reg   <= ld_dy[DELTA_W-1];
                delta_major_reg <= ld_dmaj;
                delta_minor_reg <= ld_dy[DELTA_W-1] ? -ld_dy : ld_dy;
                error_acc_reg   <= '0;
                colour_reg[0]   <= clamp_colour(red_in);
                colour_reg[1]   <= clamp_colour(green_in);
                colour_reg[2]   <= clamp_colour(blue_in);
                colour_reg[3]   <= clamp_colour(alpha_in);
            end
            else if (tick_acc && active_reg)
            begin
                if (minor_step)
                begin
                    minor_pos_reg <= minor_dir_reg ? minor_pos_reg - COORD_W'(1)
                                                   : minor_pos_reg + COORD_W'(1);
                    error_acc_reg <= err_add - signed'(ERR_W'(delta_major_reg));
                end
                else
                    error_acc_reg <= err_add;
                if (pix_last)
                    active_reg <= 1'b0;
                else
                    major_pos_reg <= major_pos_reg + COORD_W'(1);
            end

            if (tick_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (px_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            if (active_reg)
            begin
                s1_x_reg      <= x_pb[COORD_W-1:0];
                s1_y_reg      <= y_pb[COORD_W-1:0];
                s1_w_reg      <= w_eff;
                s1_on_reg     <= pix_on;
                s1_last_reg   <= pix_last;
                s1_idle_reg   <= 1'b0;
                s1_colour_reg <= colour_reg;
            end
            else
            begin
                // tick with no line: empty pixel flagged idle
                s1_x_reg      <= '0;
                s1_y_reg      <= '0;
                s1_w_reg      <= '0;
                s1_on_reg     <= 1'b0;
                s1_last_reg   <= 1'b0;
                s1_idle_reg   <= 1'b1;
                s1_colour_reg <= '{default: '0};
            end
        end

        if (s1_adv)
        begin
            out_x_reg      <= s1_x_reg;
            out_y_reg      <= s1_y_reg;
            out_addr_reg   <= s1_on_reg ? addr_full[ADDR_W-1:0] : '0;
            out_colour_reg <= s1_colour_reg;
            out_on_reg     <= s1_on_reg;
            out_last_reg   <= s1_last_reg;
            out_idle_reg   <= s1_idle_reg;
        end
    end

    assign px_valid      = out_valid_reg;
    assign pixel_x       = out_x_reg;
    assign pixel_y       = out_y_reg;
    assign pixel_address = out_addr_reg;
    assign red_out       = out_colour_reg[0];
    assign green_out     = out_colour_reg[1];
    assign blue_out      = out_colour_reg[2];
    assign alpha_out     = out_colour_reg[3];
    assign on_screen     = out_on_reg;
    assign last_pixel    = out_last_reg;
    assign idle          = out_idle_reg;

    // the final pixel of a line ends it
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_acc && active_reg && pix_last && !load_acc) |=> !active_reg)
        else $error("line still active after its last pixel");

    // an idle word carries no pixel
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (px_valid && idle) |-> (!on_screen && !last_pixel && pixel_address == '0))
        else $error("idle word carries pixel data");

    // an on-screen pixel has nonnegative coordinates
    a_on_screen_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (px_valid && on_screen) |-> (!pixel_x[COORD_W-1] && !pixel_y[COORD_W-1]))
        else $error("on-screen pixel with negative coordinate");

    // both stages full and blocked keep the command channel stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !px_ready) |-> !cmd_ready)
        else $error("command accepted with both stages blocked");

endmodule

>>> dv/tb_bresenham_line_pixel_generator.sv
`timescale 1ns / 1ps

module tb_bresenham_line_pixel_generator;
    import blpg_pkg::*;

    localparam int SCR_MAX         = MAX_DIM_DEFAULT;
    localparam int CYCLE_LIMIT     = 300000;
    // room for the pixel pipeline to drain, a little slack on top
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASES          = 9;
    localparam int FIXED_SCREENS   = 7;
    localparam int WORDS_PER_PHASE = 200;
    localparam int PRINT_CAP       = 40;
    localparam int DIR_ROWS        = 26;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    // one command word as it sits on the command channel
    typedef struct packed {
        logic                       kind;
        logic signed [COORD_W-1:0]  sx, sy, ex, ey;
        logic signed [COL_IN_W-1:0] red, green, blue, alpha;
    } cmd_word_t;

    // one pixel word as it sits on the pixel channel
    typedef struct packed {
        logic signed [COORD_W-1:0] x, y;
        logic [ADDR_W-1:0]         addr;
        logic [COL_W-1:0]          red, green, blue, alpha;
        logic                      on, last, idle;
    } pixel_word_t;

    // directed row: the word, and a hand-typed pixel where it is obvious
    typedef struct packed {
        cmd_word_t   cmd;
        logic        typed;
        pixel_word_t pix;
    } dir_row_t;

    localparam cmd_word_t   TICK_WORD  = '{kind: KIND_TICK, default: '0};
    localparam pixel_word_t IDLE_PIXEL = '{idle: 1'b1, default: '0};
    localparam pixel_word_t NO_PIXEL   = '0;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // tick straight out of reset: no line, idle pixel
        '{TICK_WORD, 1'b1, IDLE_PIXEL},
        // single-point line with colours above, below and inside the range
        '{'{KIND_LOAD, 14'sd5, 14'sd7, 14'sd5, 14'sd7,
            16'sd300, -16'sd5, 16'sd128, 16'sd255}, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b1, '{14'sd5, 14'sd7, 24'd4485, 8'd255, 8'd0, 8'd128, 8'd255,
            1'b1, 1'b1, 1'b0}},
        '{TICK_WORD, 1'b1, IDLE_PIXEL},
        // point sitting exactly on width and height, pulled back to the corner
        '{'{KIND_LOAD, 14'sd640, 14'sd480, 14'sd640, 14'sd480,
            16'sd255, 16'sd0, 16'sd0, 16'sd32767}, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b1, '{14'sd639, 14'sd479, 24'd307199, 8'd255, 8'd0, 8'd0, 8'd255,
            1'b1, 1'b1, 1'b0}},
        // most negative coordinates and colour extremes
        '{'{KIND_LOAD, 14'sh2000, 14'sh2000, 14'sh2000, 14'sh2000,
            16'sh8000, 16'sd32767, 16'sd0, 16'sd1}, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b1, '{14'sh2000, 14'sh2000, 24'd0, 8'd0, 8'd255, 8'd0, 8'd1,
            1'b0, 1'b1, 1'b0}},
        // most positive coordinates
        '{'{KIND_LOAD, 14'sd8191, 14'sd8191, 14'sd8191, 14'sd8191,
            16'sd255, 16'sd256, -16'sd1, 16'sd254}, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b1, '{14'sd8191, 14'sd8191, 24'd0, 8'd255, 8'd255, 8'd0, 8'd254,
            1'b0, 1'b1, 1'b0}},
        // shallow rising line, cut short by the next load
        '{'{KIND_LOAD, 14'sd0, 14'sd0, 14'sd6, 14'sd2,
            16'sd10, 16'sd20, 16'sd30, 16'sd40}, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL},
        // steep line with a falling minor axis, loaded over the active one
        '{'{KIND_LOAD, 14'sd0, 14'sd5, 14'sd4, 14'sd0,
            16'sd1, 16'sd2, 16'sd3, 16'sd4}, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL},
        // line finished, next tick is idle
        '{TICK_WORD, 1'b1, IDLE_PIXEL},
        // diagonal crossing the bottom right corner of the screen
        '{'{KIND_LOAD, 14'sd638, 14'sd479, 14'sd641, 14'sd482,
            -16'sd1, 16'sd100, 16'sd200, 16'sd300}, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL},
        '{TICK_WORD, 1'b0, NO_PIXEL}
    };

    // dut ports, all inputs known from time zero
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]       cfg_index = REG_SCREEN_WIDTH;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       cmd_valid = 1'b0;
    logic                       cmd_ready;
    logic                       kind = KIND_LOAD;
    logic signed [COORD_W-1:0]  start_x = '0;
    logic signed [COORD_W-1:0]  start_y = '0;
    logic signed [COORD_W-1:0]  end_x = '0;
    logic signed [COORD_W-1:0]  end_y = '0;
    logic signed [COL_IN_W-1:0] red_in = '0;
    logic signed [COL_IN_W-1:0] green_in = '0;
    logic signed [COL_IN_W-1:0] blue_in = '0;
    logic signed [COL_IN_W-1:0] alpha_in = '0;
    logic                       px_valid;
    logic                       px_ready = 1'b0;
    logic signed [COORD_W-1:0]  pixel_x;
    logic signed [COORD_W-1:0]  pixel_y;
    logic [ADDR_W-1:0]          pixel_address;
    logic [COL_W-1:0]           red_out;
    logic [COL_W-1:0]           green_out;
    logic [COL_W-1:0]           blue_out;
    logic [COL_W-1:0]           alpha_out;
    logic                       on_screen;
    logic                       last_pixel;
    logic                       idle;

    // screen size as the block should currently see it
    logic [CFG_W-1:0]           scr_w = WIDTH_RESET;
    logic [CFG_W-1:0]           scr_h = HEIGHT_RESET;

    // line walker state, mirrors what the block holds between ticks
    bit                         ln_active;
    bit                         ln_steep;
    bit                         ln_minor_neg;
    int                         ln_major, ln_major_end, ln_minor;
    int                         ln_d_major, ln_d_minor, ln_err;
    logic [COL_W-1:0]           ln_colour [NUM_CHAN];

    pixel_word_t                pending_pixels [$];
    pixel_word_t                rx_want;
    idle_mode_e                 idle_mode = IDLE_NONE;
    int                         tx_burst = 0;
    int                         rx_burst = 0;
    int                         words_sent = 0;
    int                         pixels_seen = 0;
    int                         mismatches = 0;
    int                         cycle_count = 0;

    bresenham_line_pixel_generator #(
        .MAX_DIM(SCR_MAX)
    ) u_top (
        .*
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case the handshake hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("bresenham_line_pixel_generator test failed");
            $finish;
        end
    end

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // screen sizes above the supported maximum behave as the maximum
    function automatic int eff_dim(input logic [CFG_W-1:0] d);
        return (d > SCR_MAX) ? SCR_MAX : int'(d);
    endfunction

    function automatic logic [COL_W-1:0] saturate(input logic signed [COL_IN_W-1:0] c);
        if (c < 0)
            return '0;
        if (c > 255)
            return 8'd255;
        return c[COL_W-1:0];
    endfunction

    // per-cycle idle chance for one side in the current phase
    function automatic int stall_pct(input bit sender_side);
        if (idle_mode == IDLE_BOTH)
            return 24;
        if (idle_mode == (sender_side ? IDLE_SENDER : IDLE_RECEIVER))
            return 55;
        return 0;
    endfunction

    function automatic logic signed [COL_IN_W-1:0] rand_channel();
        // half full range, half around the clamp window
        if ($urandom_range(1) == 0)
            return COL_IN_W'($urandom);
        return COL_IN_W'(int'($urandom_range(295)) - 20);
    endfunction

    function automatic cmd_word_t random_word(input logic k);
        cmd_word_t c;
        c.kind  = k;
        c.sx    = COORD_W'($urandom);
        c.sy    = COORD_W'($urandom);
        c.ex    = COORD_W'($urandom);
        c.ey    = COORD_W'($urandom);
        c.red   = rand_channel();
        c.green = rand_channel();
        c.blue  = rand_channel();
        c.alpha = rand_channel();
        return c;
    endfunction

    // short line starting on or just around the visible screen
    function automatic cmd_word_t near_line_word();
        cmd_word_t c;
        int x0, y0, reach;
        c = random_word(KIND_LOAD);
        reach = ($urandom_range(9) == 0) ? 200 : 24;
        x0 = int'($urandom_range(eff_dim(scr_w) + 8)) - 4;
        y0 = int'($urandom_range(eff_dim(scr_h) + 8)) - 4;
        c.sx = COORD_W'(x0);
        c.sy = COORD_W'(y0);
        c.ex = COORD_W'(x0 + int'($urandom_range(2 * reach)) - reach);
        c.ey = COORD_W'(y0 + int'($urandom_range(2 * reach)) - reach);
        return c;
    endfunction

    // advance the line walker by one accepted word, give back its pixel if any
    task automatic walk_line(input cmd_word_t c, output bit emits, output pixel_word_t pix);
        int  x0, y0, x1, y1, t, dy, w, h, px, py;
        bit  on, last;
        pix   = '0;
        emits = 1'b0;
        if (c.kind == KIND_LOAD)
        begin
            x0 = $signed(c.sx);
            y0 = $signed(c.sy);
            x1 = $signed(c.ex);
            y1 = $signed(c.ey);
            // steep lines walk along y, so swap the axes
            ln_steep = mag(x0 - x1) < mag(y0 - y1);
            if (ln_steep)
            begin
                t = x0; x0 = y0; y0 = t;
                t = x1; x1 = y1; y1 = t;
            end
            // always walk the major axis upward
            if (x0 > x1)
            begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            dy            = y1 - y0;
            ln_minor_neg  = dy < 0;
            ln_major      = x0;
            ln_major_end  = x1;
            ln_minor      = y0;
            ln_d_major    = x1 - x0;
            ln_d_minor    = mag(dy);
            ln_err        = 0;
            ln_colour[0]  = saturate(c.red);
            ln_colour[1]  = saturate(c.green);
            ln_colour[2]  = saturate(c.blue);
            ln_colour[3]  = saturate(c.alpha);
            ln_active     = 1'b1;
        end
        else if (!ln_active)
        begin
            emits    = 1'b1;
            pix.idle = 1'b1;
        end
        else
        begin
            w  = eff_dim(scr_w);
            h  = eff_dim(scr_h);
            px = ln_steep ? ln_minor : ln_major;
            py = ln_steep ? ln_major : ln_minor;
            // a coordinate right on the far edge is pulled back by one
            if (px == w)
                px--;
            if (py == h)
                py--;
            on   = (px >= 0) && (px < w) && (py >= 0) && (py < h);
            last = ln_major >= ln_major_end;

            emits     = 1'b1;
            pix.x     = COORD_W'(px);
            pix.y     = COORD_W'(py);
            pix.addr  = on ? ADDR_W'(px + py * w) : '0;
            pix.red   = ln_colour[0];
            pix.green = ln_colour[1];
            pix.blue  = ln_colour[2];
            pix.alpha = ln_colour[3];
            pix.on    = on;
            pix.last  = last;

            // error rule for the next pixel
            ln_err += ln_d_minor;
            if (2 * ln_err > ln_d_major)
            begin
                ln_minor += ln_minor_neg ? -1 : 1;
                ln_err   -= ln_d_major;
            end
            if (last)
                ln_active = 1'b0;
            else
                ln_major++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at pixel %0d: %s got 0x%0h expected 0x%0h",
                     pixels_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_pixel(input pixel_word_t want);
        if (pixel_x !== want.x)
            report_mismatch("pixel_x", pixel_x, want.x);
        if (pixel_y !== want.y)
            report_mismatch("pixel_y", pixel_y, want.y);
        if (pixel_address !== want.addr)
            report_mismatch("pixel_address", pixel_address, want.addr);
        if (red_out !== want.red)
            report_mismatch("red_out", red_out, want.red);
        if (green_out !== want.green)
            report_mismatch("green_out", green_out, want.green);
        if (blue_out !== want.blue)
            report_mismatch("blue_out", blue_out, want.blue);
        if (alpha_out !== want.alpha)
            report_mismatch("alpha_out", alpha_out, want.alpha);
        if (on_screen !== want.on)
            report_mismatch("on_screen", on_screen, want.on);
        if (last_pixel !== want.last)
            report_mismatch("last_pixel", last_pixel, want.last);
        if (idle !== want.idle)
            report_mismatch("idle", idle, want.idle);
    endtask

    // drive one command word and hold it until the block takes it
    // entered and left right after a rising edge
    task automatic send_word(input cmd_word_t c, input bit typed, input pixel_word_t typed_pix);
        int          gap;
        bit          emits;
        pixel_word_t pix;
        gap = 0;
        if (tx_burst > 0)
            tx_burst--;
        else if ($urandom_range(31) == 0)
            tx_burst = $urandom_range(30, 8);
        else
            while ($urandom_range(99) < stall_pct(1'b1))
                gap++;
        // valid only drops when a real gap follows
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        kind      <= c.kind;
        start_x   <= c.sx;
        start_y   <= c.sy;
        end_x     <= c.ex;
        end_y     <= c.ey;
        red_in    <= c.red;
        green_in  <= c.green;
        blue_in   <= c.blue;
        alpha_in  <= c.alpha;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        walk_line(c, emits, pix);
        if (emits)
            pending_pixels.push_back(typed ? typed_pix : pix);
        words_sent++;
    endtask

    // stop sending and wait for the pipeline to empty
    task automatic flush_pixels();
        cmd_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // pixel side: values read at the edge are the ones the block presented
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (px_valid && px_ready)
            begin
                if (pending_pixels.size() == 0)
                    report_mismatch("pixel word with nothing pending", 1, 0);
                else
                begin
                    rx_want = pending_pixels.pop_front();
                    check_pixel(rx_want);
                end
                pixels_seen++;
            end
            // back-pressure, broken up by stretches of steady ready
            if (rx_burst > 0)
            begin
                rx_burst <= rx_burst - 1;
                px_ready <= 1'b1;
            end
            else if ($urandom_range(31) == 0)
            begin
                rx_burst <= $urandom_range(30, 8);
                px_ready <= 1'b1;
            end
            else
                px_ready <= ($urandom_range(99) >= stall_pct(1'b0));
        end
    end

    initial
    begin
        cmd_word_t        c;
        int               r, len, t, ticks, phase_end;
        logic [CFG_W-1:0] new_w, new_h;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed words at the reset screen size, no idling
        for (int i = 0; i < DIR_ROWS; i++)
            send_word(DIR_TABLE[i].cmd, DIR_TABLE[i].typed, DIR_TABLE[i].pix);

        for (int p = 0; p < PHASES; p++)
        begin
            flush_pixels();

            // screen sizes: reset, one pixel, max, oversize, zero, tiny, oversize width with short height, then random
            case (p)
                0: begin new_w = 13'd640;  new_h = 13'd480;  end
                1: begin new_w = 13'd1;    new_h = 13'd1;    end
                2: begin new_w = 13'd4096; new_h = 13'd4096; end
                3: begin new_w = 13'd8191; new_h = 13'd8191; end
                4: begin new_w = 13'd0;    new_h = 13'd0;    end
                5: begin new_w = 13'd16;   new_h = 13'd12;   end
                6: begin new_w = 13'd4097; new_h = 13'd3;    end
                7:
                begin
                    new_w = CFG_W'($urandom_range(SCR_MAX, 1));
                    new_h = CFG_W'($urandom_range(SCR_MAX, 1));
                end
                default:
                begin
                    new_w = CFG_W'($urandom);
                    new_h = CFG_W'($urandom);
                end
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= REG_SCREEN_WIDTH;
            cfg_data  <= new_w;
            @(posedge clk);
            scr_w      = new_w;
            cfg_index <= REG_SCREEN_HEIGHT;
            cfg_data  <= new_h;
            @(posedge clk);
            scr_h      = new_h;
            cfg_we    <= 1'b0;

            idle_mode = idle_mode_e'(p % 4);
            phase_end = words_sent + WORDS_PER_PHASE;
            while (words_sent < phase_end)
            begin
                r = $urandom_range(99);
                if (r < 75)
                begin
                    // well-formed line: load, then walk it to the end and a bit past, or sometimes cut it short
                    c   = near_line_word();
                    len = mag(int'($signed(c.ex)) - int'($signed(c.sx)));
                    t   = mag(int'($signed(c.ey)) - int'($signed(c.sy)));
                    if (t > len)
                        len = t;
                    if ($urandom_range(99) < 15)
                        ticks = $urandom_range(len);
                    else
                        ticks = len + 1 + $urandom_range(2);
                    send_word(c, 1'b0, NO_PIXEL);
                    repeat (ticks) send_word(random_word(KIND_TICK), 1'b0, NO_PIXEL);
                end
                else if (r < 90)
                begin
                    // full-range endpoints, only a few steps before the next load
                    send_word(random_word(KIND_LOAD), 1'b0, NO_PIXEL);
                    repeat ($urandom_range(3)) send_word(random_word(KIND_TICK), 1'b0, NO_PIXEL);
                end
                else
                begin
                    // noise: stray ticks and loads in any order
                    repeat ($urandom_range(3, 1))
                        send_word(random_word(1'($urandom)), 1'b0, NO_PIXEL);
                end
            end
        end

        flush_pixels();
        if (pending_pixels.size() != 0)
            report_mismatch("pixels never delivered", pending_pixels.size(), 0);
        if (mismatches == 0)
            $display("bresenham_line_pixel_generator test passed");
        else
            $display("bresenham_line_pixel_generator test failed");
        $finish;
    end

endmodule
